// ===== design/tlnt_pkg.sv =====
// Package for the two-level name table: sizes, request/status codes,
// payload structs and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package tlnt_pkg;

	localparam int MAX_DIRS   = 16;
	localparam int MAX_FILES  = 16;
	localparam int NAME_BYTES = 8;

	localparam int KEY_BITS  = 8 * NAME_BYTES;
	localparam int DIR_IW    = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
	localparam int DIR_CW    = $clog2(MAX_DIRS + 1);
	localparam int FILE_IW   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int FILE_CW   = $clog2(MAX_FILES + 1);
	localparam int MEM_DEPTH = MAX_DIRS * MAX_FILES;
	localparam int FADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_DELETE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_DIR  = 2'd1,
		ST_NO_FILE = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [63:0] dir_key;
		logic [63:0] file_key;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] dir_slot;
		logic [3:0] file_slot;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CREATE,
		S_DIR_SCAN,
		S_FILE_SCAN,
		S_DEL_RD,
		S_DEL_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic create;
		logic dir_scan;
		logic file_scan;
		logic del_rd;
		logic del_wr;
	} cmd_t;

	typedef struct packed {
		logic dir_hit;
		logic dir_end;
		logic file_hit;
		logic file_end;
		logic del_req;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/tlnt_ctrl.sv =====
// Controller for the two-level name table: request sequencing FSM.
// Depends on tlnt_pkg.
`default_nettype none

module tlnt_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  tlnt_pkg::req_type_t req_type,
	input  tlnt_pkg::stat_t     stat,
	output tlnt_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done
);

	tlnt_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlnt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tlnt_pkg::S_IDLE: begin
				if (start) begin
					unique case (req_type)
						tlnt_pkg::REQ_CREATE: state_nxt = tlnt_pkg::S_CREATE;
						tlnt_pkg::REQ_INSERT: state_nxt = tlnt_pkg::S_DIR_SCAN;
						tlnt_pkg::REQ_SEARCH,
						tlnt_pkg::REQ_DELETE: state_nxt = tlnt_pkg::S_FILE_SCAN;
						default:              state_nxt = tlnt_pkg::S_IDLE;
					endcase
				end
			end
			tlnt_pkg::S_CREATE: state_nxt = tlnt_pkg::S_RESP;
			tlnt_pkg::S_DIR_SCAN: begin
				if (stat.dir_hit || stat.dir_end) state_nxt = tlnt_pkg::S_RESP;
			end
			tlnt_pkg::S_FILE_SCAN: begin
				if (stat.file_hit) begin
					state_nxt = stat.del_req ? tlnt_pkg::S_DEL_RD : tlnt_pkg::S_RESP;
				end else if (stat.file_end) begin
					state_nxt = tlnt_pkg::S_RESP;
				end
			end
			tlnt_pkg::S_DEL_RD: state_nxt = tlnt_pkg::S_DEL_WR;
			tlnt_pkg::S_DEL_WR: state_nxt = tlnt_pkg::S_RESP;
			tlnt_pkg::S_RESP:   state_nxt = tlnt_pkg::S_IDLE;
			default:            state_nxt = tlnt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == tlnt_pkg::S_IDLE) && start;
		cmd.create    = (state_q == tlnt_pkg::S_CREATE);
		cmd.dir_scan  = (state_q == tlnt_pkg::S_DIR_SCAN);
		cmd.file_scan = (state_q == tlnt_pkg::S_FILE_SCAN);
		cmd.del_rd    = (state_q == tlnt_pkg::S_DEL_RD);
		cmd.del_wr    = (state_q == tlnt_pkg::S_DEL_WR);
		busy          = (state_q != tlnt_pkg::S_IDLE);
		done          = (state_q == tlnt_pkg::S_RESP);
	end

endmodule

`default_nettype wire

// ===== design/tlnt_dp.sv =====
// Datapath for the two-level name table: directory names, file counts,
// file name memory, scan counters and the result register.
// Depends on tlnt_pkg.
`default_nettype none

module tlnt_dp (
	input  wire              clk,
	input  wire              arst_n,
	input  tlnt_pkg::req_t   request,
	input  tlnt_pkg::cmd_t   cmd,
	output tlnt_pkg::stat_t  stat,
	output tlnt_pkg::res_t   result
);

	localparam int DIR_IW  = tlnt_pkg::DIR_IW;
	localparam int DIR_CW  = tlnt_pkg::DIR_CW;
	localparam int FILE_IW = tlnt_pkg::FILE_IW;
	localparam int FILE_CW = tlnt_pkg::FILE_CW;
	localparam int KEY_B   = tlnt_pkg::KEY_BITS;
	localparam int FADDR_W = tlnt_pkg::FADDR_W;

	function automatic logic [FADDR_W-1:0] faddr(input logic [DIR_IW-1:0] d,
		input logic [FILE_IW-1:0] f);
		faddr = FADDR_W'(d) * FADDR_W'(tlnt_pkg::MAX_FILES) + FADDR_W'(f);
	endfunction

	// control state
	logic [DIR_CW-1:0]  dir_count_q;
	logic [FILE_CW-1:0] file_counts_q [tlnt_pkg::MAX_DIRS];
	logic [DIR_CW-1:0]  ad_q;
	logic [FILE_CW-1:0] af_q;
	logic               rd_vld_s1;

	// payload
	logic [KEY_B-1:0]   dir_names_q [tlnt_pkg::MAX_DIRS];
	logic [KEY_B-1:0]   mem [tlnt_pkg::MEM_DEPTH];
	logic [KEY_B-1:0]   mem_rdata_q;
	logic [KEY_B-1:0]   dkey_q, fkey_q;
	logic               del_q;
	logic [DIR_IW-1:0]  rd_d_s1, fd_q;
	logic [FILE_IW-1:0] rd_f_s1, ff_q;
	tlnt_pkg::res_t     res_q, res_nxt;

	logic [DIR_IW-1:0]  cur_d, dc_idx;
	logic [FILE_CW-1:0] cur_cnt, last_f;
	logic               dir_end, dir_hit, file_hit, file_end, issue;
	logic               ins_full, tbl_full, ins_we, res_we, mem_we;
	logic [FADDR_W-1:0] waddr, raddr;
	logic [KEY_B-1:0]   wdata;

	always_comb begin
		cur_d    = ad_q[DIR_IW-1:0];
		dc_idx   = dir_count_q[DIR_IW-1:0];
		cur_cnt  = file_counts_q[cur_d];
		last_f   = file_counts_q[fd_q] - FILE_CW'(1);
		dir_end  = (ad_q >= dir_count_q);
		dir_hit  = !dir_end && (dir_names_q[cur_d] == dkey_q);
		issue    = !dir_end && (af_q < cur_cnt);
		file_hit = rd_vld_s1 && (mem_rdata_q == fkey_q);
		file_end = dir_end && !rd_vld_s1;
		ins_full = (cur_cnt >= FILE_CW'(tlnt_pkg::MAX_FILES));
		tbl_full = (dir_count_q >= DIR_CW'(tlnt_pkg::MAX_DIRS));
		ins_we   = cmd.dir_scan && dir_hit && !ins_full;

		stat.dir_hit  = dir_hit;
		stat.dir_end  = dir_end;
		stat.file_hit = file_hit;
		stat.file_end = file_end;
		stat.del_req  = del_q;

		// delete moves the last file (read in the previous cycle) into the hole
		mem_we = ins_we || cmd.del_wr;
		if (cmd.del_wr) begin
			waddr = faddr(fd_q, ff_q);
			wdata = mem_rdata_q;
		end else begin
			waddr = faddr(cur_d, cur_cnt[FILE_IW-1:0]);
			wdata = fkey_q;
		end
		raddr = cmd.del_rd ? faddr(fd_q, last_f[FILE_IW-1:0])
		                   : faddr(cur_d, af_q[FILE_IW-1:0]);
	end

	always_comb begin
		res_we  = 1'b0;
		res_nxt = '{status: tlnt_pkg::ST_DONE, dir_slot: 4'd0, file_slot: 4'd0};
		if (cmd.create) begin
			res_we = 1'b1;
			if (tbl_full) begin
				res_nxt.status = tlnt_pkg::ST_FULL;
			end else begin
				res_nxt.dir_slot = 4'(dir_count_q);
			end
		end else if (cmd.dir_scan) begin
			if (dir_hit) begin
				res_we           = 1'b1;
				res_nxt.dir_slot = 4'(cur_d);
				if (ins_full) begin
					res_nxt.status = tlnt_pkg::ST_FULL;
				end else begin
					res_nxt.file_slot = 4'(cur_cnt);
				end
			end else if (dir_end) begin
				res_we         = 1'b1;
				res_nxt.status = tlnt_pkg::ST_NO_DIR;
			end
		end else if (cmd.file_scan) begin
			if (file_hit) begin
				res_we            = 1'b1;
				res_nxt.dir_slot  = 4'(rd_d_s1);
				res_nxt.file_slot = 4'(rd_f_s1);
			end else if (file_end) begin
				res_we         = 1'b1;
				res_nxt.status = tlnt_pkg::ST_NO_FILE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_count_q <= '0;
			ad_q        <= '0;
			af_q        <= '0;
			rd_vld_s1   <= 1'b0;
			for (int i = 0; i < tlnt_pkg::MAX_DIRS; i++) begin
				file_counts_q[i] <= '0;
			end
		end else begin
			rd_vld_s1 <= cmd.file_scan && issue;
			if (cmd.load) begin
				ad_q <= '0;
				af_q <= '0;
			end else if (cmd.dir_scan && !dir_hit && !dir_end) begin
				ad_q <= ad_q + DIR_CW'(1);
			end else if (cmd.file_scan) begin
				// one slot per cycle; an exhausted directory steps on to the next one without a read
				if (issue) begin
					af_q <= af_q + FILE_CW'(1);
				end else if (!dir_end) begin
					ad_q <= ad_q + DIR_CW'(1);
					af_q <= '0;
				end
			end
			if (cmd.create && !tbl_full) begin
				dir_count_q           <= dir_count_q + DIR_CW'(1);
				file_counts_q[dc_idx] <= '0;
			end
			if (ins_we) begin
				file_counts_q[cur_d] <= cur_cnt + FILE_CW'(1);
			end
			if (cmd.del_wr) begin
				file_counts_q[fd_q] <= last_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dkey_q <= request.dir_key[KEY_B-1:0];
			fkey_q <= request.file_key[KEY_B-1:0];
			del_q  <= (request.req_type == tlnt_pkg::REQ_DELETE);
		end
		if (cmd.create && !tbl_full) begin
			dir_names_q[dc_idx] <= dkey_q;
		end
		if (cmd.file_scan && file_hit) begin
			fd_q <= rd_d_s1;
			ff_q <= rd_f_s1;
		end
		if (res_we) begin
			res_q <= res_nxt;
		end
		rd_d_s1 <= cur_d;
		rd_f_s1 <= af_q[FILE_IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		mem_rdata_q <= mem[raddr];
	end

	assign result = res_q;

endmodule

`default_nettype wire

// ===== design/two_level_name_table_core.sv =====
// Two-level name table: create, insert, search, delete. Needs tlnt_pkg, tlnt_ctrl, tlnt_dp.
// One request at a time; busy drops in the cycle after done, and the next request can be
// accepted at the end of that cycle. done marks the result for one cycle; no stall input.
// Create fills the next directory slot; insert scans the directories in order; search and
// delete scan the file slots of each directory in turn (one file slot or one directory step at a time).
// A delete that hits then reads the last file and moves it into the hole. Reset clears all counts.
`default_nettype none

module two_level_name_table_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  tlnt_pkg::req_t  request,
	output logic            busy,
	output logic            done,
	output tlnt_pkg::res_t  result
);

	tlnt_pkg::cmd_t  cmd;
	tlnt_pkg::stat_t stat;

	tlnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (request.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	tlnt_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done outside a busy request");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held more than one cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == tlnt_pkg::ST_NO_DIR ||
		          result.status == tlnt_pkg::ST_NO_FILE))
		|-> (result.dir_slot == 4'd0 && result.file_slot == 4'd0))
		else $error("miss result with nonzero slots");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for two_level_name_table_core. It covers create, insert,
// search and delete requests, with a predictor kept inside the bench.
// Depends on tlnt_pkg and the core RTL.
module tb;
	import tlnt_pkg::*;

	localparam logic [63:0] KEY_MASK = 64'((65'd1 << KEY_BITS) - 65'd1);

	logic clk;
	logic arst_n;
	logic start;
	req_t request;
	logic busy;
	logic done;
	res_t result;

	two_level_name_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// predicted table contents
	int          dir_count;
	logic [63:0] dir_names [MAX_DIRS];
	int          file_counts [MAX_DIRS];
	logic [63:0] file_names [MEM_DEPTH];

	res_t pending_results [$];
	res_t oldest;
	int   errors;
	int   n_sent;
	int   status_seen [4];
	bit   no_idle;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("two_level_name_table_core test failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic res_t predict_table_op(input req_t rq);
		res_t        r;
		logic [63:0] dk;
		logic [63:0] fk;
		int          d;
		int          f;
		int          n;
		bit          hit;
		r = '0;
		r.status = ST_DONE;
		dk = rq.dir_key & KEY_MASK;
		fk = rq.file_key & KEY_MASK;
		hit = 1'b0;
		case (rq.req_type)
			REQ_CREATE: begin
				if (dir_count >= MAX_DIRS) begin
					r.status = ST_FULL;
				end else begin
					dir_names[dir_count] = dk;
					file_counts[dir_count] = 0;
					r.dir_slot = 4'(dir_count);
					dir_count++;
				end
			end
			REQ_INSERT: begin
				for (d = 0; d < dir_count; d++) begin
					if (dir_names[d] == dk) begin
						hit = 1'b1;
						break;
					end
				end
				if (!hit) begin
					r.status = ST_NO_DIR;
				end else if (file_counts[d] >= MAX_FILES) begin
					r.status = ST_FULL;
					r.dir_slot = 4'(d);
				end else begin
					n = file_counts[d];
					file_names[d * MAX_FILES + n] = fk;
					file_counts[d] = n + 1;
					r.dir_slot = 4'(d);
					r.file_slot = 4'(n);
				end
			end
			default: begin
				// search and delete: first hit over directories, then positions
				for (d = 0; d < dir_count && !hit; d++) begin
					for (f = 0; f < file_counts[d]; f++) begin
						if (file_names[d * MAX_FILES + f] == fk) begin
							hit = 1'b1;
							break;
						end
					end
					if (hit)
						break;
				end
				if (!hit) begin
					r.status = ST_NO_FILE;
				end else begin
					if (rq.req_type == REQ_DELETE) begin
						n = file_counts[d];
						file_names[d * MAX_FILES + f] = file_names[d * MAX_FILES + n - 1];
						file_counts[d] = n - 1;
					end
					r.dir_slot = 4'(d);
					r.file_slot = 4'(f);
				end
			end
		endcase
		return r;
	endfunction

	function automatic req_t mk_req(input req_type_t t, input logic [63:0] dk,
			input logic [63:0] fk);
		req_t rq;
		rq.req_type = t;
		rq.dir_key = dk;
		rq.file_key = fk;
		return rq;
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] known_dir_key();
		if (dir_count == 0)
			return rand_key();
		return dir_names[$urandom_range(0, dir_count - 1)];
	endfunction

	function automatic logic [63:0] known_file_key();
		int total;
		int k;
		total = 0;
		for (int d = 0; d < dir_count; d++)
			total += file_counts[d];
		if (total == 0)
			return rand_key();
		k = $urandom_range(0, total - 1);
		for (int d = 0; d < dir_count; d++) begin
			if (k < file_counts[d])
				return file_names[d * MAX_FILES + k];
			k -= file_counts[d];
		end
		return rand_key();
	endfunction

	// inputs move on the falling edge; acceptance is seen at the rising edge
	task automatic send_request(input req_t rq);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_table_op(rq));
		n_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			status_seen[result.status]++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %p with no request waiting", result));
			end else begin
				oldest = pending_results.pop_front();
				if (result.status !== oldest.status)
					report_mismatch($sformatf("status %0d, predicted %0d",
						result.status, oldest.status));
				if (result.dir_slot !== oldest.dir_slot)
					report_mismatch($sformatf("dir_slot %0d, predicted %0d",
						result.dir_slot, oldest.dir_slot));
				if (result.file_slot !== oldest.file_slot)
					report_mismatch($sformatf("file_slot %0d, predicted %0d",
						result.file_slot, oldest.file_slot));
			end
		end
	end

	task automatic test_empty_lookups();
		send_request(mk_req(REQ_SEARCH, '0, '0));
		send_request(mk_req(REQ_DELETE, '1, '1));
		send_request(mk_req(REQ_INSERT, '0, '1));
	endtask

	task automatic test_basic_ops();
		logic [63:0] k;
		k = 64'h0123_4567_89ab_cdef;
		send_request(mk_req(REQ_CREATE, '1, '0));
		send_request(mk_req(REQ_CREATE, '0, '1));
		// duplicate name: inserts must land in the first one
		send_request(mk_req(REQ_CREATE, '1, rand_key()));
		send_request(mk_req(REQ_INSERT, '1, '0));
		send_request(mk_req(REQ_INSERT, '0, '1));
		send_request(mk_req(REQ_INSERT, '1, k));
		send_request(mk_req(REQ_INSERT, '1, ~k));
		send_request(mk_req(REQ_INSERT, 64'h5555_aaaa_5555_aaaa, k));
		send_request(mk_req(REQ_SEARCH, '0, '1));
		send_request(mk_req(REQ_SEARCH, '1, '0));
		send_request(mk_req(REQ_SEARCH, '0, 64'h8000_0000_0000_0001));
		// delete slot 0: the last file moves into it
		send_request(mk_req(REQ_DELETE, rand_key(), '0));
		send_request(mk_req(REQ_SEARCH, rand_key(), ~k));
		send_request(mk_req(REQ_DELETE, rand_key(), ~k));
		send_request(mk_req(REQ_DELETE, rand_key(), ~k));
		send_request(mk_req(REQ_DELETE, rand_key(), '1));
		send_request(mk_req(REQ_SEARCH, rand_key(), '1));
	endtask

	task automatic test_full_directory();
		logic [63:0] dk;
		dk = rand_key();
		send_request(mk_req(REQ_CREATE, dk, rand_key()));
		for (int i = 0; i < MAX_FILES; i++)
			send_request(mk_req(REQ_INSERT, dk, rand_key()));
		send_request(mk_req(REQ_INSERT, dk, rand_key()));
		send_request(mk_req(REQ_DELETE, rand_key(), known_file_key()));
		send_request(mk_req(REQ_INSERT, dk, '1));
	endtask

	task automatic test_random_traffic(input int items);
		int          pick;
		logic [63:0] dk;
		logic [63:0] fk;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 39) == 0)
				no_idle = ~no_idle;
			pick = $urandom_range(0, 99);
			fk = ($urandom_range(0, 3) != 0) ? known_file_key() : rand_key();
			dk = ($urandom_range(0, 9) != 0) ? known_dir_key() : rand_key();
			if (pick < 4)
				send_request(mk_req(REQ_CREATE, ($urandom_range(0, 4) == 0) ?
					known_dir_key() : rand_key(), rand_key()));
			else if (pick < 44)
				send_request(mk_req(REQ_INSERT, dk, ($urandom_range(0, 2) == 0) ?
					known_file_key() : rand_key()));
			else if (pick < 70)
				send_request(mk_req(REQ_SEARCH, rand_key(), fk));
			else
				send_request(mk_req(REQ_DELETE, rand_key(), fk));
		end
		no_idle = 1'b0;
	endtask

	task automatic test_full_table();
		while (dir_count < MAX_DIRS)
			send_request(mk_req(REQ_CREATE, rand_key(), rand_key()));
		send_request(mk_req(REQ_CREATE, '1, '1));
		send_request(mk_req(REQ_CREATE, '0, '0));
		// missing keys force a scan of the whole table
		for (int i = 0; i < 4; i++)
			send_request(mk_req(REQ_SEARCH, rand_key(), rand_key()));
		send_request(mk_req(REQ_DELETE, rand_key(), rand_key()));
		send_request(mk_req(REQ_INSERT, known_dir_key(), rand_key()));
		send_request(mk_req(REQ_SEARCH, rand_key(), known_file_key()));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		errors = 0;
		n_sent = 0;
		no_idle = 1'b0;
		dir_count = 0;
		foreach (file_counts[i])
			file_counts[i] = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_lookups();
		test_basic_ops();
		test_full_directory();
		test_random_traffic(600);
		test_full_table();

		@(negedge clk);
		start <= 1'b0;
		for (int i = 0; i < 2000 && pending_results.size() != 0; i++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d predicted results never arrived",
				pending_results.size()));

		$display("Sent %0d requests over %0d directories; results: %0d done, %0d no dir,",
			n_sent, dir_count, status_seen[ST_DONE], status_seen[ST_NO_DIR]);
		$display("  %0d no file, %0d full; %0d mismatches.",
			status_seen[ST_NO_FILE], status_seen[ST_FULL], errors);
		if (errors == 0)
			$display("two_level_name_table_core test passed");
		else
			$display("two_level_name_table_core test failed");
		$finish;
	end

endmodule
